/* hw/rtl/hsdc_pkg.sv */
package hsdc_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned REG_W  = 31;
	localparam int unsigned NUM_AXES = 3;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [REG_W-1:0] creg_t;

	typedef enum logic [1:0] {
		REG_STIFFNESS = 2'd0,
		REG_DAMPING   = 2'd1,
		REG_MAX_OFF   = 2'd2,
		REG_MAX_TILT  = 2'd3
	} reg_idx_t;

	// Per-lane control from the sequencer
	typedef struct packed {
		logic start;
		logic load_h;
	} lane_ctrl_t;

	// Saturate a wide signed value to the 32-bit range
	function automatic word_t sat32(input logic signed [95:0] x);
		if (x > 96'sd2147483647) begin
			return word_t'(32'h7fffffff);
		end else if (x < -96'sd2147483648) begin
			return word_t'(32'h80000000);
		end
		return word_t'(x[31:0]);
	endfunction

endpackage

/* hw/rtl/hsdc_if.sv */
interface hsdc_in_if;
	import hsdc_pkg::*;
	logic  valid;
	logic  ready;
	word_t time_step;
	word_t accel_vertical;
	word_t accel_lateral;
	word_t accel_longitudinal;
	word_t body_pitch_in;
	word_t body_roll_in;
	modport source (output valid, time_step, accel_vertical, accel_lateral,
		accel_longitudinal, body_pitch_in, body_roll_in, input ready);
	modport sink (input valid, time_step, accel_vertical, accel_lateral,
		accel_longitudinal, body_pitch_in, body_roll_in, output ready);
endinterface

interface hsdc_out_if;
	import hsdc_pkg::*;
	logic  valid;
	logic  ready;
	word_t offset_x;
	word_t offset_y;
	word_t offset_z;
	word_t tilt_roll;
	word_t tilt_pitch;
	modport source (output valid, offset_x, offset_y, offset_z, tilt_roll, tilt_pitch,
		input ready);
	modport sink (input valid, offset_x, offset_y, offset_z, tilt_roll, tilt_pitch,
		output ready);
endinterface

/* hw/rtl/hsdc_div.sv */
// Restoring divider on magnitudes, one quotient bit a cycle, truncates toward zero
module hsdc_div
	import hsdc_pkg::*;
#(
	parameter int unsigned NUM_W = 64,
	parameter int unsigned DEN_W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic                    busy,
	output logic signed [NUM_W-1:0] quo
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign busy  = (cnt_q != '0);
	assign quo   = neg_q ? -$signed(mag_q) : $signed(mag_q);

	// Shift one numerator bit into the remainder per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			neg_q <= num[NUM_W-1];
			den_q <= den;
			rem_q <= '0;
		end else if (busy) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				mag_q <= {mag_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				mag_q <= {mag_q[NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule

/* hw/rtl/hsdc_lane.sv */
// One axis of the spring-damper: the lane is busy while a substep runs L_MUL1..L_POS
module hsdc_lane
	import hsdc_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  word_t      accel,
	input  word_t      h,
	input  creg_t      stiffness,
	input  creg_t      damping,
	input  creg_t      pos_limit,
	output logic       busy,
	output word_t      pos
);
	typedef enum logic [2:0] {L_IDLE, L_MUL1, L_ACC, L_MUL2, L_POS} lstate_t;

	lstate_t state_q;
	word_t pos_q, vel_q;
	logic signed [34:0] half_q;
	logic signed [63:0] kp_s1, cv_s1, prod_s1;
	logic signed [65:0] a_wide;
	logic signed [63:0] acc_drive;
	logic signed [95:0] vnew, pnew;
	logic signed [32:0] lim;

	assign busy = (state_q != L_IDLE) || ctrl.start;
	assign pos  = pos_q;
	assign lim  = $signed({2'b00, pos_limit});

	assign acc_drive = 64'(accel) * 64'sd5;
	assign a_wide = -66'(kp_s1 >>> FRAC_BITS) - 66'(cv_s1 >>> FRAC_BITS) - 66'(half_q);
	assign vnew = 96'(vel_q) + 96'(prod_s1 >>> FRAC_BITS);
	assign pnew = 96'(pos_q) + 96'(prod_s1 >>> FRAC_BITS);

	// Step through the multiplies of one substep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			pos_q   <= '0;
			vel_q   <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: if (ctrl.start) state_q <= L_MUL1;
				L_MUL1: state_q <= L_ACC;
				L_ACC:  state_q <= L_MUL2;
				L_MUL2: begin
					vel_q   <= sat32(vnew);
					state_q <= L_POS;
				end
				L_POS: begin
					if (pnew > 96'(lim)) pos_q <= word_t'(lim);
					else if (pnew < -96'(lim)) pos_q <= word_t'(-lim);
					else pos_q <= word_t'(pnew);
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.load_h) begin
			half_q <= 35'(acc_drive >>> 1);
		end
		unique case (state_q)
			L_MUL1: begin
				kp_s1 <= 64'($signed({1'b0, stiffness})) * 64'(pos_q);
				cv_s1 <= 64'($signed({1'b0, damping})) * 64'(vel_q);
			end
			L_ACC:   prod_s1 <= 64'(sat32(96'(a_wide))) * 64'(h);
			L_MUL2:  prod_s1 <= 64'(sat32(vnew)) * 64'(h);
			default: ;
		endcase
	end
endmodule

/* hw/rtl/head_spring_damper_camera_step_top.sv */
// Head spring-damper camera step. Each request runs ceil(time_step/0.05 s) substeps
// (1..MAX_SUBSTEPS) of a semi-implicit Euler update, with the three axes in parallel
// lanes. A positive step first divides time_step by the substep count in a serial
// divider; then two serial 64-bit divisions, run together, form the tilts. A
// non-positive step skips integration and goes straight to the tilt divisions. A
// result still waiting on the output holds the final step of the next item.
// The result register frees the input once the result is loaded.
module head_spring_damper_camera_step_top
	import hsdc_pkg::*;
#(
	parameter int unsigned MAX_SUBSTEPS = 64,
	parameter int unsigned FRAC_BITS    = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data,
	hsdc_in_if.sink      in_ch,
	hsdc_out_if.source   out_ch
);
	localparam int unsigned SUB_W = $clog2(MAX_SUBSTEPS + 1);
	localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam longint EPS_RAW = (ONE_Q + 500) / 1000;
	localparam longint EPS_Q = (EPS_RAW > 0) ? EPS_RAW : 1;

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_RUN, S_WAIT, S_TILT, S_TWAIT, S_OUT}
		state_t;

	state_t state_q;
	creg_t k_q, c_q, mo_q, mt_q;
	word_t dt_q, pitch_q, roll_q;
	logic [SUB_W-1:0] n_q, i_q;
	logic [SUB_W-1:0] nsat;
	word_t h_q;
	lane_ctrl_t lctrl;
	logic [NUM_AXES-1:0] lbusy;
	word_t lpos [NUM_AXES];
	logic d0_start, d0_busy, dt_start, dr_busy, dp_busy;
	logic signed [63:0] d0_quo, dr_quo, dp_quo;
	logic [62:0] nraw;
	logic [30:0] den;
	logic signed [63:0] ry_s1, px_s1;

	// Substep count from the time step
	assign nraw = 63'((64'(dt_q) * 64'sd20 + ONE_Q - 1) >>> FRAC_BITS);
	assign den  = (64'(mo_q) > EPS_Q) ? mo_q : 31'(EPS_Q);

	// Limit the substep count to 1..MAX_SUBSTEPS
	always_comb begin
		priority if (nraw > 63'(MAX_SUBSTEPS)) nsat = SUB_W'(MAX_SUBSTEPS);
		else if (nraw < 63'd1) nsat = SUB_W'(1);
		else nsat = SUB_W'(nraw);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= 31'd62914560;
			c_q  <= 31'd8388608;
			mo_q <= 31'd52429;
			mt_q <= 31'd52429;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STIFFNESS: k_q  <= cfg_data;
				REG_DAMPING:   c_q  <= cfg_data;
				REG_MAX_OFF:   mo_q <= cfg_data;
				REG_MAX_TILT:  mt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign d0_start = (state_q == S_IDLE) && in_ch.valid && (in_ch.time_step > 0);
	assign lctrl.load_h = d0_start;
	assign lctrl.start = (state_q == S_RUN);
	assign dt_start = (state_q == S_TILT);

	hsdc_div #(.NUM_W(64), .DEN_W(32)) u_div_h (
		.clk, .arst_n, .start(state_q == S_DIV && n_q == '0),
		.num(64'(dt_q)), .den(32'(nsat)), .busy(d0_busy), .quo(d0_quo));

	hsdc_div #(.NUM_W(64), .DEN_W(32)) u_div_r (
		.clk, .arst_n, .start(dt_start), .num(-ry_s1), .den({1'b0, den}),
		.busy(dr_busy), .quo(dr_quo));

	hsdc_div #(.NUM_W(64), .DEN_W(32)) u_div_p (
		.clk, .arst_n, .start(dt_start), .num(-px_s1), .den({1'b0, den}),
		.busy(dp_busy), .quo(dp_quo));

	hsdc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (.clk, .arst_n, .ctrl(lctrl),
		.accel(in_ch.accel_longitudinal), .h(h_q), .stiffness(k_q), .damping(c_q),
		.pos_limit(mo_q), .busy(lbusy[0]), .pos(lpos[0]));
	hsdc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (.clk, .arst_n, .ctrl(lctrl),
		.accel(in_ch.accel_lateral), .h(h_q), .stiffness(k_q), .damping(c_q),
		.pos_limit(mo_q), .busy(lbusy[1]), .pos(lpos[1]));
	hsdc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (.clk, .arst_n, .ctrl(lctrl),
		.accel(in_ch.accel_vertical), .h(h_q), .stiffness(k_q), .damping(c_q),
		.pos_limit(mo_q), .busy(lbusy[2]), .pos(lpos[2]));

	function automatic word_t clamp_tilt(input logic signed [63:0] q, input word_t b,
		input creg_t m);
		logic signed [65:0] s;
		s = 66'(q) + 66'(b);
		if (s > 66'($signed({1'b0, m}))) return word_t'({1'b0, m});
		if (s < -66'($signed({1'b0, m}))) return word_t'(-$signed({1'b0, m}));
		return word_t'(s);
	endfunction

	// Sequencer: count substeps, then merge lane positions into tilts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			i_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					n_q <= '0;
					state_q <= (in_ch.time_step > 0) ? S_DIV : S_TILT;
				end
				S_DIV: begin
					if (n_q == '0) begin
						n_q <= nsat;
						i_q <= '0;
					end else if (!d0_busy) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					i_q <= i_q + 1'b1;
					state_q <= S_WAIT;
				end
				S_WAIT: if (lbusy == '0)
					state_q <= (i_q == n_q) ? S_TILT : S_RUN;
				S_TILT: state_q <= S_TWAIT;
				S_TWAIT: if (!dr_busy && !dp_busy && (!out_ch.valid || out_ch.ready))
					state_q <= S_OUT;
				S_OUT: begin
					out_ch.valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			dt_q <= in_ch.time_step;
			pitch_q <= in_ch.body_pitch_in;
			roll_q <= in_ch.body_roll_in;
		end
		if (state_q == S_DIV && n_q != '0 && !d0_busy) h_q <= word_t'(d0_quo);
		ry_s1 <= 64'(lpos[1]) * 64'($signed({1'b0, mt_q}));
		px_s1 <= 64'(lpos[0]) * 64'($signed({1'b0, mt_q}));
		if (state_q == S_OUT) begin
			out_ch.offset_x <= lpos[0];
			out_ch.offset_y <= lpos[1];
			out_ch.offset_z <= lpos[2];
			out_ch.tilt_roll <= clamp_tilt(dr_quo, roll_q, mt_q);
			out_ch.tilt_pitch <= clamp_tilt(dp_quo, pitch_q, mt_q);
		end
	end

	// Input is only taken with no substep work in flight
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (lbusy == '0)) else $error("accept while lanes busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (i_q < n_q)) else $error("substep overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
endmodule
